>>> sv/bbf_pkg.sv
// Shared types and codes for the bounded byte FIFO.
package bbf_pkg;

  localparam int FIELD_W = 13;
  localparam int TOTAL_W = 64;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_CLOSED = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
  } bbf_cmd_t;

endpackage

>>> sv/bbf_ctrl.sv
// Request sequencer for the bounded byte FIFO.
module bbf_ctrl
  import bbf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bbf_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_READ;
      S_READ: state_next = S_RESP;
      S_RESP: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_RESP);
  assign cmd.capture = in_valid && (state == S_IDLE);
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.read    = (state == S_READ);

endmodule

>>> sv/bbf_datapath.sv
// Byte store, pointers, counters and capacity register of the bounded byte FIFO.
module bbf_datapath
  import bbf_pkg::*;
#(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bbf_cmd_t             cmd,
  input  logic                 cfg_wr_en,
  input  logic [FIELD_W-1:0]   cfg_wr_data,
  input  logic [1:0]           action,
  input  logic [7:0]           push_byte,
  input  logic [FIELD_W-1:0]   pop_length,
  output logic [1:0]           status,
  output logic [7:0]           front_byte,
  output logic                 front_valid,
  output logic [FIELD_W-1:0]   held_count,
  output logic [FIELD_W-1:0]   free_space,
  output logic [TOTAL_W-1:0]   total_pushed,
  output logic [TOTAL_W-1:0]   total_popped,
  output logic                 stream_closed,
  output logic                 is_done
);

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int CW     = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  logic [7:0]         mem [STORE_DEPTH];
  logic [7:0]         mem_q;

  action_t            act_q;
  logic [7:0]         byte_q;
  logic [FIELD_W-1:0] len_q;
  logic [FIELD_W-1:0] cap_reg;

  logic [ADDR_W-1:0]  rd_ptr;
  logic [ADDR_W-1:0]  rd_ptr_next;
  logic [ADDR_W-1:0]  wr_ptr;
  logic [ADDR_W-1:0]  wr_ptr_next;
  logic [CNT_W-1:0]   held;
  logic [CNT_W-1:0]   held_next;
  logic [TOTAL_W-1:0] pushed;
  logic [TOTAL_W-1:0] pushed_next;
  logic [TOTAL_W-1:0] popped;
  logic [TOTAL_W-1:0] popped_next;
  logic               closed;
  logic               closed_next;
  status_t            status_q;
  status_t            status_next;
  logic               mem_we;

  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      cap_eff;
  logic [CW-1:0]      held_ext;
  logic [CW-1:0]      len_ext;
  logic [CW-1:0]      amount;
  logic [CW:0]        rd_sum;

  assign cap_ext  = CW'(cap_reg);
  assign cap_eff  = (cap_ext > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : cap_ext;
  assign held_ext = CW'(held);
  assign len_ext  = CW'(len_q);
  assign amount   = (len_ext < held_ext) ? len_ext : held_ext;
  assign rd_sum   = (CW + 1)'(rd_ptr) + (CW + 1)'(amount);

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    held_next   = held;
    pushed_next = pushed;
    popped_next = popped;
    closed_next = closed;
    status_next = ST_DONE;
    mem_we      = 1'b0;
    case (act_q)
      ACT_PUSH: begin
        if (closed) begin
          status_next = ST_CLOSED;
        end else if (held_ext >= cap_eff) begin
          status_next = ST_FULL;
        end else begin
          mem_we      = 1'b1;
          wr_ptr_next = (wr_ptr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
          held_next   = held + 1'b1;
          pushed_next = pushed + 1'b1;
        end
      end
      ACT_POP: begin
        if (rd_sum >= (CW + 1)'(STORE_DEPTH)) begin
          rd_ptr_next = ADDR_W'(rd_sum - (CW + 1)'(STORE_DEPTH));
        end else begin
          rd_ptr_next = ADDR_W'(rd_sum);
        end
        held_next   = held - CNT_W'(amount);
        popped_next = popped + TOTAL_W'(amount);
      end
      ACT_CLOSE: closed_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= action_t'(action);
      byte_q <= push_byte;
      len_q  <= pop_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[wr_ptr] <= byte_q;
    end
    if (cmd.read) begin
      mem_q <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg  <= FIELD_W'(4096);
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      held     <= '0;
      pushed   <= '0;
      popped   <= '0;
      closed   <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      if (cfg_wr_en) begin
        cap_reg <= cfg_wr_data;
      end
      if (cmd.exec) begin
        rd_ptr   <= rd_ptr_next;
        wr_ptr   <= wr_ptr_next;
        held     <= held_next;
        pushed   <= pushed_next;
        popped   <= popped_next;
        closed   <= closed_next;
        status_q <= status_next;
      end
    end
  end

  assign status        = status_q;
  assign front_valid   = (held != '0);
  assign front_byte    = front_valid ? mem_q : 8'd0;
  assign held_count    = FIELD_W'(held);
  assign free_space    = FIELD_W'((held_ext < cap_eff) ? cap_eff - held_ext : '0);
  assign total_pushed  = pushed;
  assign total_popped  = popped;
  assign stream_closed = closed;
  assign is_done       = closed && !front_valid;

endmodule

>>> sv/bounded_byte_stream_fifo.sv
// Top level of the bounded byte FIFO: sequencer plus datapath.
//
//   channel  handshake              carries
//   in       in_valid / in_ready    action, push_byte, pop_length
//   out      out_valid / out_ready  status, front_byte, front_valid, held_count,
//                                   free_space, total_pushed, total_popped,
//                                   stream_closed, is_done
//   cfg      cfg_wr_en              cfg_wr_data (capacity limit)
//
// Each request goes in order through capture, execute (store write and pointer update),
// store read of the new front entry, and then its result is offered on out.
// The byte store is read after the update, so front_byte shows the new front entry.
// rst clears pointers, counts, totals and the closed flag; capacity resets to 4096.
// A stalled result keeps its outputs but free_space; in_ready stays low until taken.
module bounded_byte_stream_fifo
  import bbf_pkg::*;
#(
  parameter int STORE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [7:0]         push_byte,
  input  logic [FIELD_W-1:0] pop_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [7:0]         front_byte,
  output logic               front_valid,
  output logic [FIELD_W-1:0] held_count,
  output logic [FIELD_W-1:0] free_space,
  output logic [TOTAL_W-1:0] total_pushed,
  output logic [TOTAL_W-1:0] total_popped,
  output logic               stream_closed,
  output logic               is_done,
  input  logic               cfg_wr_en,
  input  logic [FIELD_W-1:0] cfg_wr_data
);

  bbf_cmd_t cmd;

  bbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bbf_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .action        (action),
    .push_byte     (push_byte),
    .pop_length    (pop_length),
    .status        (status),
    .front_byte    (front_byte),
    .front_valid   (front_valid),
    .held_count    (held_count),
    .free_space    (free_space),
    .total_pushed  (total_pushed),
    .total_popped  (total_popped),
    .stream_closed (stream_closed),
    .is_done       (is_done)
  );

endmodule

>>> test/bounded_byte_stream_fifo_checker.sv
// Checker for the bounded byte FIFO: predicts each result and compares it field by field.
module bounded_byte_stream_fifo_checker
  import bbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         action,
  input  logic [7:0]         push_byte,
  input  logic [FIELD_W-1:0] pop_length,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [7:0]         front_byte,
  input  logic               front_valid,
  input  logic [FIELD_W-1:0] held_count,
  input  logic [FIELD_W-1:0] free_space,
  input  logic [TOTAL_W-1:0] total_pushed,
  input  logic [TOTAL_W-1:0] total_popped,
  input  logic               stream_closed,
  input  logic               is_done,
  input  logic               cfg_wr_en,
  input  logic [FIELD_W-1:0] cfg_wr_data,
  output int                 failures,
  output int                 outstanding
);

  localparam logic [FIELD_W-1:0] DEPTH = 13'd4096;

  typedef struct {
    status_t            status;
    logic [7:0]         front;
    logic               front_valid;
    logic [FIELD_W-1:0] held;
    logic [FIELD_W-1:0] free;
    logic [TOTAL_W-1:0] pushed;
    logic [TOTAL_W-1:0] popped;
    logic               closed;
    logic               drained;
  } fifo_view_t;

  logic [7:0]         mem [0:4095];
  logic [11:0]        head;
  logic [11:0]        tail;
  logic [FIELD_W-1:0] level;
  logic [TOTAL_W-1:0] pushed_count;
  logic [TOTAL_W-1:0] popped_count;
  logic               closed;
  logic [FIELD_W-1:0] capacity;
  fifo_view_t         predicted_views [$];
  fifo_view_t         want;

  function automatic fifo_view_t step_fifo(action_t act, logic [7:0] b,
                                           logic [FIELD_W-1:0] len);
    fifo_view_t v;
    logic [FIELD_W-1:0] room_limit;
    logic [FIELD_W-1:0] amount;
    room_limit = (capacity > DEPTH) ? DEPTH : capacity;
    v.status = ST_DONE;
    case (act)
      ACT_PUSH: begin
        if (closed) begin
          v.status = ST_CLOSED;
        end else if (level >= room_limit) begin
          v.status = ST_FULL;
        end else begin
          mem[tail] = b;
          tail = tail + 12'd1;
          level = level + 13'd1;
          pushed_count = pushed_count + 64'd1;
        end
      end
      ACT_POP: begin
        amount = (len < level) ? len : level;
        head = head + amount[11:0];
        level = level - amount;
        popped_count = popped_count + TOTAL_W'(amount);
      end
      ACT_CLOSE: begin
        closed = 1'b1;
      end
      default: begin
      end
    endcase
    v.front = (level != 0) ? mem[head] : 8'd0;
    v.front_valid = (level != 0);
    v.held = level;
    v.free = (level < room_limit) ? room_limit - level : 13'd0;
    v.pushed = pushed_count;
    v.popped = popped_count;
    v.closed = closed;
    v.drained = closed && (level == 0);
    return v;
  endfunction

  function automatic void check_field(string name, logic [TOTAL_W-1:0] exp_val,
                                      logic [TOTAL_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head = '0;
      tail = '0;
      level = '0;
      pushed_count = '0;
      popped_count = '0;
      closed = 1'b0;
      capacity = DEPTH;
      failures = 0;
      predicted_views.delete();
    end else begin
      if (cfg_wr_en) begin
        capacity = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (predicted_views.size() == 0) begin
          $error("result arrived with no request outstanding");
          failures++;
        end else begin
          want = predicted_views.pop_front();
          check_field("status", want.status, status);
          check_field("front_byte", want.front, front_byte);
          check_field("front_valid", want.front_valid, front_valid);
          check_field("held_count", want.held, held_count);
          check_field("free_space", want.free, free_space);
          check_field("total_pushed", want.pushed, total_pushed);
          check_field("total_popped", want.popped, total_popped);
          check_field("stream_closed", want.closed, stream_closed);
          check_field("is_done", want.drained, is_done);
        end
      end
      if (in_valid && in_ready) begin
        predicted_views.push_back(step_fifo(action_t'(action), push_byte, pop_length));
      end
    end
    outstanding <= predicted_views.size();
  end

endmodule

>>> test/bounded_byte_stream_fifo_test.sv
// Testbench top for the bounded byte FIFO: clock, reset, stimulus and verdict.
module bounded_byte_stream_fifo_test
  import bbf_pkg::*;
();

  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = ACT_NONE;
  logic [7:0]         push_byte = 8'd0;
  logic [FIELD_W-1:0] pop_length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [7:0]         front_byte;
  logic               front_valid;
  logic [FIELD_W-1:0] held_count;
  logic [FIELD_W-1:0] free_space;
  logic [TOTAL_W-1:0] total_pushed;
  logic [TOTAL_W-1:0] total_popped;
  logic               stream_closed;
  logic               is_done;
  logic               cfg_wr_en = 1'b0;
  logic [FIELD_W-1:0] cfg_wr_data = '0;
  int                 failures;
  int                 outstanding;
  int                 cycle_count = 0;
  int                 ready_hold = 0;
  int                 ready_draw;
  bit                 calm = 1'b0;
  logic [FIELD_W-1:0] phase_caps [8];

  bounded_byte_stream_fifo u_top (.*);

  bounded_byte_stream_fifo_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bounded_byte_stream_fifo_test: errors");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 1);
  endfunction

  // Hold ready low for a drawn number of cycles after each taken result.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_valid && out_ready) begin
      ready_draw = draw_wait();
      if (ready_draw != 0) begin
        out_ready <= 1'b0;
        ready_hold <= ready_draw - 1;
      end
    end else if (!out_ready) begin
      if (ready_hold == 0) begin
        out_ready <= 1'b1;
      end else begin
        ready_hold <= ready_hold - 1;
      end
    end
  end

  task automatic send_request(action_t act, logic [7:0] b, logic [FIELD_W-1:0] len);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    push_byte <= b;
    pop_length <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_request(int push_pct, bit allow_close);
    int pick;
    int span;
    logic [7:0] b;
    logic [FIELD_W-1:0] len;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 9);
    b = 8'($urandom_range(0, 255));
    if (span < 6) len = 13'($urandom_range(0, 3));
    else if (span < 9) len = 13'($urandom_range(0, 64));
    else len = 13'($urandom_range(0, 8191));
    if (pick < push_pct) send_request(ACT_PUSH, b, len);
    else if (pick < 96) send_request(ACT_POP, b, len);
    else if (pick < 98 || !allow_close) send_request(ACT_NONE, b, len);
    else send_request(ACT_CLOSE, b, len);
  endtask

  // Drain all outstanding requests before touching the capacity register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [FIELD_W-1:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(ACT_POP, 8'h00, 13'd0);
    send_request(ACT_POP, 8'hFF, 13'h1FFF);
    send_request(ACT_NONE, 8'h11, 13'd7);
    send_request(ACT_PUSH, 8'h00, 13'h1FFF);
    send_request(ACT_PUSH, 8'hFF, 13'd0);
    send_request(ACT_PUSH, 8'h55, 13'd0);
    send_request(ACT_PUSH, 8'hAA, 13'd0);
    send_request(ACT_POP, 8'h00, 13'd1);
    send_request(ACT_POP, 8'h00, 13'd0);
    send_request(ACT_NONE, 8'hFF, 13'h1FFF);
    send_request(ACT_POP, 8'h00, 13'd4096);

    write_capacity(13'd0);
    send_request(ACT_PUSH, 8'h7F, 13'd0);
    send_request(ACT_POP, 8'h00, 13'd5);

    write_capacity(13'd2);
    send_request(ACT_PUSH, 8'h01, 13'd0);
    send_request(ACT_PUSH, 8'h02, 13'd0);
    send_request(ACT_PUSH, 8'h03, 13'd0);

    write_capacity(13'd1);
    send_request(ACT_PUSH, 8'h04, 13'd0);
    send_request(ACT_POP, 8'h00, 13'd1);
    send_request(ACT_PUSH, 8'h05, 13'd0);
    send_request(ACT_POP, 8'h00, 13'd1);
    send_request(ACT_PUSH, 8'h3C, 13'd0);

    phase_caps = '{13'h1FFF, 13'd5, 13'd1, 13'd4096, 13'd0,
                   13'($urandom_range(2, 40)), 13'($urandom_range(100, 4095)), 13'd3};
    foreach (phase_caps[p]) begin
      int push_pct;
      write_capacity(phase_caps[p]);
      push_pct = $urandom_range(45, 85);
      for (int i = 0; i < 240; i++) begin
        if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
        random_request(push_pct, 1'b0);
      end
    end

    calm = 1'b0;
    write_capacity(13'd2);
    send_request(ACT_POP, 8'h00, 13'h1FFF);
    send_request(ACT_PUSH, 8'hC3, 13'd0);
    send_request(ACT_PUSH, 8'h3C, 13'd0);
    send_request(ACT_PUSH, 8'h99, 13'd0);
    send_request(ACT_CLOSE, 8'h00, 13'd0);
    send_request(ACT_PUSH, 8'h66, 13'd0);
    send_request(ACT_CLOSE, 8'h00, 13'd0);
    for (int i = 0; i < 40; i++) begin
      random_request(50, 1'b1);
    end
    send_request(ACT_POP, 8'h00, 13'h1FFF);
    send_request(ACT_PUSH, 8'hFF, 13'd0);
    send_request(ACT_CLOSE, 8'h00, 13'd0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("bounded_byte_stream_fifo_test: clean");
    end else begin
      $display("bounded_byte_stream_fifo_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bbf_pkg.sv
sv/bbf_ctrl.sv
sv/bbf_datapath.sv
sv/bounded_byte_stream_fifo.sv
test/bounded_byte_stream_fifo_checker.sv
test/bounded_byte_stream_fifo_test.sv
